>>> rtl/tcw_pkg.sv
// Shared item kinds, control character codes, the reset attribute and the cell type for the text console.
`timescale 1ns / 1ps

package tcw_pkg;

	// item kinds
	localparam logic [1:0] KIND_PUT   = 2'd0;
	localparam logic [1:0] KIND_CLEAR = 2'd1;
	localparam logic [1:0] KIND_SET   = 2'd2;
	localparam logic [1:0] KIND_READ  = 2'd3;

	// control characters
	localparam logic [7:0] CH_BS    = 8'd8;
	localparam logic [7:0] CH_TAB   = 8'd9;
	localparam logic [7:0] CH_NL    = 8'd10;
	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_SPACE = 8'd32;

	localparam logic [7:0] ATTR_RESET = 8'd7;

	typedef logic [15:0] cell_t;	// {attribute, character}

endpackage

>>> rtl/text_console_writer.sv
// Text console engine: cell store memory, cursor, scroll and clear sequencer.
`timescale 1ns / 1ps

// Put, set-cursor and read-cell items: the store write or read lands at the accept edge,
//   then the item waits in the done state until the output register is free and loads it.
// No new item is taken until the result has moved on into the output register.
// Scroll (newline, wrap or tab past the last row): one store entry per cycle for the copy
//   of rows 1..ROWS-1 up one row and the bottom-line fill. Clear: spaces over every cell.
// Reset: cursor to 0,0, attribute to 7. The cell store is undefined until a clear item.
module text_console_writer #(
	parameter int COLUMNS   = 80,
	parameter int ROWS      = 25,
	parameter int TAB_WIDTH = 8
) (
	input  logic       clk,
	input  logic       arst_n,

	// attribute register write
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] cfg_data,

	// input items
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] kind,
	input  logic [7:0] char_code,
	input  logic [4:0] row_in,
	input  logic [6:0] col_in,

	// result items
	output logic        out_valid,
	input  logic        out_stall,
	output logic [4:0]  pos_row,
	output logic [6:0]  pos_col,
	output logic [10:0] cursor_offset,
	output logic [7:0]  cell_char,
	output logic [7:0]  cell_color
);

	localparam int CELLS = ROWS * COLUMNS;
	localparam int AW    = $clog2(CELLS);
	localparam int CIW   = $clog2(COLUMNS);

	// sequencer states
	localparam logic [1:0] ST_IDLE = 2'd0;	// waiting for an item
	localparam logic [1:0] ST_COPY = 2'd1;	// scroll: move rows 1..ROWS-1 up one row
	localparam logic [1:0] ST_FILL = 2'd2;	// write spaces over a range of cells
	localparam logic [1:0] ST_DONE = 2'd3;	// result waits for the output register

	logic [1:0] state_q;
	logic [AW-1:0] cnt_q;
	logic [4:0] cur_row_q;
	logic [6:0] cur_col_q;
	logic [7:0] color_q;
	logic rd_item_q;

	// cell store: one write port, one registered read port
	tcw_pkg::cell_t mem [CELLS];
	tcw_pkg::cell_t rd_data_q;
	logic rd_en;
	logic [AW-1:0] rd_addr;
	logic wr_en;
	logic [AW-1:0] wr_addr;
	tcw_pkg::cell_t wr_data;

	// scroll copy pipeline: read at cnt, write the registered data one row up, at cnt - COLUMNS
	logic cp_vld_s1;
	logic [AW-1:0] cp_addr_s1;

	// output register
	logic out_valid_q;
	logic [4:0] out_row_q;
	logic [6:0] out_col_q;
	logic [10:0] out_off_q;
	logic [7:0] out_char_q;
	logic [7:0] out_color_q;

	logic accept;
	logic out_load;

	// decode of the item at the input
	logic [5:0] row_inc;
	logic [7:0] col_inc;
	logic [7:0] tab_col;
	logic [4:0] row_clamp;
	logic [6:0] col_clamp;
	logic [4:0] nxt_row;
	logic [6:0] nxt_col;
	logic line_adv;
	logic scroll;
	logic put_we;
	logic [6:0] put_col;
	logic [7:0] put_char;
	logic [AW-1:0] put_addr;
	logic [AW-1:0] read_addr;

	// next tab stop for each column
	logic [7:0] tab_stop [COLUMNS];
	for (genvar gi = 0; gi < COLUMNS; gi++) begin : g_tab
		assign tab_stop[gi] = 8'(((gi / TAB_WIDTH) + 1) * TAB_WIDTH);
	end

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_load  = (state_q == ST_DONE) && (!out_valid_q || !out_stall);

	always_comb begin
		row_inc   = {1'b0, cur_row_q} + 6'd1;
		col_inc   = {1'b0, cur_col_q} + 8'd1;
		tab_col   = tab_stop[cur_col_q[CIW-1:0]];
		row_clamp = (row_in > 5'(ROWS - 1)) ? 5'(ROWS - 1) : row_in;
		col_clamp = (col_in > 7'(COLUMNS - 1)) ? 7'(COLUMNS - 1) : col_in;
		nxt_row   = cur_row_q;
		nxt_col   = cur_col_q;
		line_adv  = 1'b0;
		scroll    = 1'b0;
		put_we    = 1'b0;
		put_col   = cur_col_q;
		put_char  = char_code;
		case (kind)
			tcw_pkg::KIND_PUT: begin
				case (char_code)
					tcw_pkg::CH_NL: line_adv = 1'b1;
					tcw_pkg::CH_CR: nxt_col = 7'd0;
					tcw_pkg::CH_TAB: begin
						if (tab_col >= 8'(COLUMNS))
							line_adv = 1'b1;
						else
							nxt_col = tab_col[6:0];
					end
					tcw_pkg::CH_BS: begin
						// nothing happens at column 0
						if (cur_col_q != 7'd0) begin
							nxt_col  = cur_col_q - 7'd1;
							put_col  = cur_col_q - 7'd1;
							put_char = tcw_pkg::CH_SPACE;
							put_we   = 1'b1;
						end
					end
					default: begin
						put_we = 1'b1;
						if (col_inc >= 8'(COLUMNS))
							line_adv = 1'b1;
						else
							nxt_col = col_inc[6:0];
					end
				endcase
			end
			tcw_pkg::KIND_CLEAR: begin
				nxt_row = 5'd0;
				nxt_col = 7'd0;
			end
			tcw_pkg::KIND_SET: begin
				nxt_row = row_clamp;
				nxt_col = col_clamp;
			end
			default: ;	// read cell leaves the cursor alone
		endcase
		if (line_adv) begin
			nxt_col = 7'd0;
			if (row_inc >= 6'(ROWS)) begin
				scroll  = 1'b1;
				nxt_row = 5'(ROWS - 1);
			end else begin
				nxt_row = row_inc[4:0];
			end
		end
	end

	assign put_addr  = AW'(cur_row_q * COLUMNS + put_col);
	assign read_addr = AW'(row_clamp * COLUMNS + col_clamp);

	// write port: pending copy write first, then fill, then the put from the input
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = put_addr;
		wr_data = {color_q, put_char};
		if (cp_vld_s1) begin
			wr_en   = 1'b1;
			wr_addr = cp_addr_s1;
			wr_data = rd_data_q;
		end else if (state_q == ST_FILL) begin
			wr_en   = 1'b1;
			wr_addr = cnt_q;
			wr_data = {color_q, tcw_pkg::CH_SPACE};
		end else if (accept && kind == tcw_pkg::KIND_PUT && put_we) begin
			wr_en = 1'b1;
		end
	end

	assign rd_en   = (state_q == ST_COPY) || (accept && kind == tcw_pkg::KIND_READ);
	assign rd_addr = (state_q == ST_COPY) ? cnt_q : read_addr;

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (rd_en)
			rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			cnt_q     <= '0;
			cur_row_q <= 5'd0;
			cur_col_q <= 7'd0;
			color_q   <= tcw_pkg::ATTR_RESET;
			cp_vld_s1 <= 1'b0;
			rd_item_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready)
				color_q <= cfg_data;
			cp_vld_s1 <= (state_q == ST_COPY);
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						cur_row_q <= nxt_row;
						cur_col_q <= nxt_col;
						rd_item_q <= (kind == tcw_pkg::KIND_READ);
						if (scroll) begin
							// the put write above lands before the first copy read
							state_q <= ST_COPY;
							cnt_q   <= AW'(COLUMNS);
						end else if (kind == tcw_pkg::KIND_CLEAR) begin
							state_q <= ST_FILL;
							cnt_q   <= '0;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_COPY: begin
					if (cnt_q == AW'(CELLS - 1)) begin
						state_q <= ST_FILL;
						cnt_q   <= AW'(CELLS - COLUMNS);
					end else begin
						cnt_q <= cnt_q + AW'(1);
					end
				end
				ST_FILL: begin
					// the pending last copy write takes the port before the fill goes on
					if (!cp_vld_s1) begin
						if (cnt_q == AW'(CELLS - 1))
							state_q <= ST_DONE;
						else
							cnt_q <= cnt_q + AW'(1);
					end
				end
				ST_DONE: begin
					if (out_load)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		cp_addr_s1 <= cnt_q - AW'(COLUMNS);
	end

	// output register: frees the input side while a result waits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_row_q   <= cur_row_q;
			out_col_q   <= cur_col_q;
			out_off_q   <= 11'(cur_row_q * COLUMNS + cur_col_q);
			out_char_q  <= rd_item_q ? rd_data_q[7:0] : 8'd0;
			out_color_q <= rd_item_q ? rd_data_q[15:8] : 8'd0;
		end
	end

	assign out_valid     = out_valid_q;
	assign pos_row       = out_row_q;
	assign pos_col       = out_col_q;
	assign cursor_offset = out_off_q;
	assign cell_char     = out_char_q;
	assign cell_color    = out_color_q;

endmodule

>>> rtl/tcw_checker.sv
// Port-level assertions for the text console and their bind to the top level.
`timescale 1ns / 1ps

module tcw_checker #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic [1:0]  kind,
	input logic [4:0]  row_in,
	input logic [6:0]  col_in,
	input logic        out_valid,
	input logic        out_stall,
	input logic [4:0]  pos_row,
	input logic [6:0]  pos_col,
	input logic [10:0] cursor_offset
);

	// a stalled result stays valid and keeps its cursor offset and column
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(cursor_offset) && $stable(pos_col))
		else $error("stalled result changed");

	a_cursor_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (pos_row <= 5'(ROWS - 1)) && (pos_col <= 7'(COLUMNS - 1)))
		else $error("cursor outside the grid");

	a_offset: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> cursor_offset == 11'(pos_row * COLUMNS + pos_col))
		else $error("cursor offset mismatch");

	// one item at a time
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("item taken while busy");

	// set cursor with a free output shows the clamped position through the done state and the output register
	a_set: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && kind == tcw_pkg::KIND_SET && !out_valid |=> ##1
		out_valid
		&& pos_row == (($past(row_in, 2) > 5'(ROWS - 1)) ? 5'(ROWS - 1) : $past(row_in, 2))
		&& pos_col == (($past(col_in, 2) > 7'(COLUMNS - 1)) ? 7'(COLUMNS - 1)
			: $past(col_in, 2)))
		else $error("set cursor result wrong");

endmodule

bind text_console_writer tcw_checker #(
	.COLUMNS(COLUMNS),
	.ROWS(ROWS)
) u_tcw_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_valid),
	.in_stall(in_stall),
	.kind(kind),
	.row_in(row_in),
	.col_in(col_in),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.pos_row(pos_row),
	.pos_col(pos_col),
	.cursor_offset(cursor_offset)
);
